// ===== rtl/core/arpc_pkg.sv =====
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 312;

  localparam logic [MAC_W-1:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] OWN_MAC_RESET = 48'h00AA_BBCC_DD04;

  // input command selector
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_RESOLVE = 1'b1;

  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;

  localparam logic [1:0] ACT_HIT = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_REQUEST = 2'd2;

  localparam logic CFG_OWN_IP = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  // classified item passed from front to back
  typedef struct packed {
    logic             resolve;
    logic             reply;
    logic [IP_W-1:0]  key_ip;
    logic [MAC_W-1:0] mac;
  } q_item_t;

  typedef struct packed {
    logic [IP_W-1:0]  arp_tpa;
    logic [MAC_W-1:0] arp_tha;
    logic [IP_W-1:0]  arp_spa;
    logic [MAC_W-1:0] arp_sha;
    logic [1:0]       arp_opcode;
    logic [MAC_W-1:0] frame_src_mac;
    logic [MAC_W-1:0] frame_dst_mac;
    logic [MAC_W-1:0] resolved_mac;
    logic [1:0]       action;
  } result_t;

endpackage

// ===== rtl/core/arpc_front.sv =====
`timescale 1ns / 1ps

module arpc_front (
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [arpc_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                             s_tuser,
  input  logic [arpc_pkg::IP_W-1:0]        own_ip,
  input  logic                             q_full,
  output logic                             q_push,
  output arpc_pkg::q_item_t                q_item
);
  import arpc_pkg::*;

  logic [15:0]      opcode;
  logic [IP_W-1:0]  pkt_spa;
  logic [MAC_W-1:0] pkt_sha;
  logic [IP_W-1:0]  pkt_tpa;

  assign opcode  = s_tdata[15:0];
  assign pkt_spa = s_tdata[47:16];
  assign pkt_sha = s_tdata[95:48];
  assign pkt_tpa = s_tdata[127:96];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // packets key the cache on the sender, resolves on the target
  always_comb begin
    q_item.resolve = (s_tuser == CMD_RESOLVE);
    q_item.reply   = (s_tuser == CMD_PACKET) && (pkt_tpa == own_ip)
                     && (opcode == ARP_OP_REQUEST);
    q_item.key_ip  = (s_tuser == CMD_RESOLVE) ? pkt_tpa : pkt_spa;
    q_item.mac     = pkt_sha;
  end

endmodule

// ===== rtl/core/arpc_queue.sv =====
`timescale 1ns / 1ps

module arpc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arpc_pkg::q_item_t push_item,
  output logic              full,
  input  logic              pop,
  output arpc_pkg::q_item_t pop_item,
  output logic              not_empty
);
  import arpc_pkg::*;

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/arpc_back.sv =====
`timescale 1ns / 1ps

module arpc_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  arpc_pkg::q_item_t           q_item,
  input  logic [arpc_pkg::IP_W-1:0]   own_ip,
  input  logic [arpc_pkg::MAC_W-1:0]  own_mac,
  output logic                        out_valid,
  input  logic                        out_ready,
  output arpc_pkg::result_t           out_res
);
  import arpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  logic [IP_W-1:0]  entry_ip  [CACHE_ENTRIES];
  logic [MAC_W-1:0] entry_mac [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] entry_valid;

  state_t           state;
  q_item_t          cur;
  logic [IDX_W-1:0] idx;
  logic             found;
  logic [MAC_W-1:0] hit_mac;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic             key_nz;
  logic             match;
  logic             need_res;
  logic             finish;
  logic             learn;
  result_t          res_next;

  assign key_nz   = (cur.key_ip != '0);
  assign match    = entry_valid[idx] && (entry_ip[idx] == cur.key_ip) && key_nz;
  assign need_res = cur.resolve || cur.reply;
  assign finish   = (state == S_DONE) && (!need_res || !out_valid || out_ready);
  // learn only once, on the cycle the item leaves the back end
  assign learn    = finish && !cur.resolve && key_nz && !found && free_found;
  assign q_pop    = (state == S_IDLE);

  always_comb begin
    res_next = '0;
    res_next.frame_src_mac = own_mac;
    if (cur.resolve && found) begin
      res_next.action        = ACT_HIT;
      res_next.resolved_mac  = hit_mac;
      res_next.frame_dst_mac = hit_mac;
    end else if (cur.resolve) begin
      res_next.action        = ACT_REQUEST;
      res_next.frame_dst_mac = BCAST_MAC;
      res_next.arp_opcode    = OP_REQUEST;
      res_next.arp_sha       = own_mac;
      res_next.arp_spa       = own_ip;
      res_next.arp_tpa       = cur.key_ip;
    end else begin
      res_next.action        = ACT_REPLY;
      res_next.frame_dst_mac = cur.mac;
      res_next.arp_opcode    = OP_REPLY;
      res_next.arp_sha       = own_mac;
      res_next.arp_spa       = own_ip;
      res_next.arp_tha       = cur.mac;
      res_next.arp_tpa       = cur.key_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (learn) begin
      entry_ip[free_idx]  <= cur.key_ip;
      entry_mac[free_idx] <= cur.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (learn) begin
      entry_valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (finish && need_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur        <= q_item;
            idx        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // keep the first hit and the first empty slot
          if (!found && match) begin
            found   <= 1'b1;
            hit_mac <= entry_mac[idx];
          end
          if (!free_found && !entry_valid[idx]) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (idx == LAST_IDX) begin
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DONE: begin
          if (finish) begin
            if (need_res) begin
              out_res <= res_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/arp_responder_with_cache.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata: opcode, spa, sha, tpa
//                                  s_tuser: command
// m_       out  m_tvalid/m_tready  m_tdata: ARP result fields, m_tuser: action
// cfg_     in   cfg_we             cfg_index, cfg_data (own_ip, own_mac)
//
// Each item occupies the cache engine while it is taken from the queue, while
// each cache entry is checked in a sequential scan, and while the engine learns
// and issues the result. A two-deep queue lets input transfers continue while
// the engine scans; a single output register holds the result.
// Synchronous reset clears the cache valid bits; own_mac resets to
// 00:aa:bb:cc:dd:04 and own_ip to zero.

module arp_responder_with_cache (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode[15:0], spa[47:16], sha[95:48], tpa[127:96]
  input  logic [127:0] s_tdata,
  // command
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // resolved_mac, frame_dst_mac, frame_src_mac, arp_opcode, arp_sha,
  // arp_spa, arp_tha, arp_tpa, zero fill [311:306]
  output logic [311:0] m_tdata,
  // action
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [47:0]  cfg_data
);
  import arpc_pkg::*;

  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  logic    q_full;
  logic    q_push;
  q_item_t q_in;
  logic    q_pop;
  q_item_t q_out;
  logic    q_not_empty;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= '0;
      own_mac <= OWN_MAC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IP:  own_ip  <= cfg_data[IP_W-1:0];
        CFG_OWN_MAC: own_mac <= cfg_data;
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .own_ip   (own_ip),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  arpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .not_empty (q_not_empty)
  );

  arpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_pop     (q_pop),
    .q_item    (q_out),
    .own_ip    (own_ip),
    .own_mac   (own_mac),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tuser = res.action;
  assign m_tdata = {6'd0, res.arp_tpa, res.arp_tha, res.arp_spa,
                    res.arp_sha, res.arp_opcode, res.frame_src_mac,
                    res.frame_dst_mac, res.resolved_mac};

  a_action_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.action == ACT_HIT || res.action == ACT_REPLY
                  || res.action == ACT_REQUEST))
    else $error("undefined action code on output");

  a_hit_no_arp: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.action == ACT_HIT) |->
      (res.arp_opcode == OP_NONE && res.arp_spa == '0
       && res.arp_tpa == '0 && res.frame_dst_mac == res.resolved_mac))
    else $error("cache hit result carries ARP frame fields");

  a_src_own_mac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.frame_src_mac == own_mac))
    else $error("frame source differs from own MAC");

  a_opcode_match: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.action != ACT_HIT) |->
      ((res.action == ACT_REPLY) == (res.arp_opcode == OP_REPLY)))
    else $error("ARP opcode does not match action");

endmodule
